/* rtl/kpsr_pkg.sv */
// kpsr_pkg: shared types and constants of the keypad scanner with key-code queue
// used by kpsr_scan, kpsr_queue and keypad_scan_repeat_fifo_core; no dependencies
`default_nettype none

package kpsr_pkg;

    // default parameter values
    localparam int QUEUE_DEPTH_DEF    = 256;
    localparam int QUEUE_CAPACITY_DEF = 254;
    localparam int TICK_MS_DEF        = 30;

    // field and state widths
    localparam int KEY_W     = 5;
    localparam int CODE_W    = 8;
    localparam int ACC_W     = 17;
    localparam int TMO_W     = 16;
    localparam int RST_CNT_W = 7;
    localparam int VID_CNT_W = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // scan constants
    localparam logic [KEY_W-1:0]     KEYS_IDLE        = 5'h1f;
    localparam logic [RST_CNT_W-1:0] RESET_HOLD_TICKS = 7'd75;
    localparam logic [VID_CNT_W-1:0] VIDEO_HOLD_TICKS = 4'd15;
    localparam logic [CODE_W-1:0]    RESET_CODE       = 8'h10;
    localparam logic [CODE_W-1:0]    VIDEO_CODE       = 8'h20;
    localparam logic [CODE_W-1:0]    EMPTY_CODE       = 8'hff;
    localparam logic [ACC_W-1:0]     ACC_MAX          = 17'h1ffff;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TIMEOUT = 1'b1;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key_lines;
        logic             reset_button;
        logic             video_detect;
    } t_in_word;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              queue_was_empty;
    } t_out_word;

    // codes raised by one scan tick, in queue order key, reset, video
    typedef struct packed {
        logic              key_v;
        logic [CODE_W-1:0] key_code;
        logic              rst_v;
        logic              vid_v;
    } t_scan_codes;

endpackage

`default_nettype wire

/* rtl/kpsr_scan.sv */
// kpsr_scan: per-tick key, auto-repeat, reset-button and video-detect logic
// depends on kpsr_pkg
`default_nettype none

module kpsr_scan #(
    parameter int TICK_MS = kpsr_pkg::TICK_MS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_tick,
    input  wire logic [kpsr_pkg::KEY_W-1:0]    i_key_lines,
    input  wire logic                          i_reset_button,
    input  wire logic                          i_video_detect,
    input  wire logic                          i_repeat_enable,
    input  wire logic [kpsr_pkg::TMO_W-1:0]    i_repeat_timeout,
    output kpsr_pkg::t_scan_codes              o_codes
);

    localparam int ACC_W = kpsr_pkg::ACC_W;
    localparam logic [ACC_W:0] ACC_INC = (ACC_W+1)'(2 * TICK_MS);

    logic [kpsr_pkg::KEY_W-1:0]     r_prev_keys, n_prev_keys;
    logic [ACC_W-1:0]               r_acc, n_acc;
    logic [kpsr_pkg::RST_CNT_W-1:0] r_rst_cnt, n_rst_cnt;
    logic [kpsr_pkg::VID_CNT_W-1:0] r_vid_cnt, n_vid_cnt;

    logic                           pressed;
    logic [ACC_W-1:0]               acc_upd;
    logic [ACC_W:0]                 acc_sum;
    logic [ACC_W-1:0]               tmo_ext;
    logic [kpsr_pkg::RST_CNT_W-1:0] rst_cnt_upd;
    logic [kpsr_pkg::VID_CNT_W-1:0] vid_cnt_upd;

    always_comb begin
        pressed = (i_key_lines != kpsr_pkg::KEYS_IDLE);
        tmo_ext = ACC_W'(i_repeat_timeout);
        acc_sum = {1'b0, r_acc} + ACC_INC;

        // hold counters
        rst_cnt_upd = i_reset_button ? '0 : r_rst_cnt + 1'b1;
        vid_cnt_upd = i_video_detect ? '0 : r_vid_cnt + 1'b1;

        // new pattern arms an immediate enqueue, held pattern accumulates
        n_prev_keys = r_prev_keys;
        acc_upd     = r_acc;
        if (i_key_lines != r_prev_keys) begin
            n_prev_keys = i_key_lines;
            acc_upd     = tmo_ext + 1'b1;
        end else if (i_repeat_enable && pressed) begin
            acc_upd = (acc_sum > {1'b0, kpsr_pkg::ACC_MAX}) ? kpsr_pkg::ACC_MAX
                                                             : acc_sum[ACC_W-1:0];
        end

        o_codes.key_v = pressed && (acc_upd > tmo_ext);
        // inverted pattern less 16 when bit 4 is set: just the low four bits
        o_codes.key_code = {4'b0000, ~i_key_lines[3:0]};
        o_codes.rst_v = (rst_cnt_upd >= kpsr_pkg::RESET_HOLD_TICKS);
        o_codes.vid_v = (vid_cnt_upd >= kpsr_pkg::VIDEO_HOLD_TICKS);

        n_acc     = o_codes.key_v ? '0 : acc_upd;
        n_rst_cnt = o_codes.rst_v ? '0 : rst_cnt_upd;
        n_vid_cnt = o_codes.vid_v ? '0 : vid_cnt_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keys <= '0;
            r_acc       <= '0;
            r_rst_cnt   <= '0;
            r_vid_cnt   <= '0;
        end else if (i_tick) begin
            r_prev_keys <= n_prev_keys;
            r_acc       <= n_acc;
            r_rst_cnt   <= n_rst_cnt;
            r_vid_cnt   <= n_vid_cnt;
        end
    end

`ifndef SYNTHESIS
    a_rst_cnt_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rst_cnt < kpsr_pkg::RESET_HOLD_TICKS)
        else $error("reset hold count reached threshold without clearing");
    a_vid_cnt_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vid_cnt < kpsr_pkg::VIDEO_HOLD_TICKS)
        else $error("video hold count reached threshold without clearing");
    a_key_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick && o_codes.key_v) |=> (r_acc == '0))
        else $error("accumulator not cleared after key enqueue");
`endif

endmodule

`default_nettype wire

/* rtl/kpsr_queue.sv */
// kpsr_queue: ring buffer of key codes, drops the oldest code when full
// one write or one read per cycle, registered read data; depends on kpsr_pkg
`default_nettype none

module kpsr_queue #(
    parameter int QUEUE_DEPTH    = kpsr_pkg::QUEUE_DEPTH_DEF,
    parameter int QUEUE_CAPACITY = kpsr_pkg::QUEUE_CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [kpsr_pkg::CODE_W-1:0]   i_wr_code,
    input  wire logic                          i_rd_en,
    output kpsr_pkg::t_out_word                o_rd_word
);

    localparam int EFF_CAP = (QUEUE_CAPACITY > QUEUE_DEPTH) ? QUEUE_DEPTH :
                             ((QUEUE_CAPACITY == 0) ? 1 : QUEUE_CAPACITY);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(EFF_CAP + 1);

    logic [kpsr_pkg::CODE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [kpsr_pkg::CODE_W-1:0] r_rd_code;
    logic                        r_rd_empty;
    logic [AW-1:0]               r_head, n_head;
    logic [CW-1:0]               r_count, n_count;

    logic [AW:0]   tail_sum;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] head_inc;
    logic          full;
    logic          empty;

    always_comb begin
        // tail = head + count, wrapped once; same slot whether or not the oldest is dropped
        tail_sum = {1'b0, r_head} + (AW+1)'(r_count);
        wr_addr  = (tail_sum >= (AW+1)'(QUEUE_DEPTH))
                   ? AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
        head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        full     = (r_count >= CW'(EFF_CAP));
        empty    = (r_count == '0);

        n_head  = r_head;
        n_count = r_count;
        if (i_wr_en) begin
            if (full) begin
                n_head = head_inc;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (i_rd_en && !empty) begin
            n_head  = head_inc;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_addr] <= i_wr_code;
        end
        if (i_rd_en) begin
            r_rd_code  <= r_mem[r_head];
            r_rd_empty <= empty;
        end
    end

    assign o_rd_word.key_code        = r_rd_empty ? kpsr_pkg::EMPTY_CODE : r_rd_code;
    assign o_rd_word.queue_was_empty = r_rd_empty;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(EFF_CAP))
        else $error("queue count above capacity");
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(QUEUE_DEPTH - 1))
        else $error("queue head outside ring");
    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr_en && i_rd_en))
        else $error("write and read in the same cycle");
`endif

endmodule

`default_nettype wire

/* rtl/keypad_scan_repeat_fifo_core.sv */
// keypad_scan_repeat_fifo_core: top level of the keypad scanner with auto-repeat
// and key-code queue; depends on kpsr_pkg, kpsr_scan and kpsr_queue
//
//  channel | signals                                  | moves
//  --------+------------------------------------------+------------------------------
//  in      | i_in_valid / o_in_ready / i_in_word      | scan tick or read command
//  out     | o_out_valid / i_out_ready / o_out_word   | one word per read command
//  cfg     | i_cfg_we / i_cfg_idx / i_cfg_data        | register write, no wait
//
//  a scan tick is evaluated in the cycle it is accepted; its up to three codes go to a
//  small pending list that drains into the ring memory at one write per cycle (memory port)
//  the next word is taken while the last pending code of a tick is written
//  a read waits for pending writes and a free output register; its word appears the next cycle
//  the output register holds a finished word while another input word is taken
//  reset (synchronous, active low) empties the queue and clears scan state; no clearing pass
`default_nettype none

module keypad_scan_repeat_fifo_core #(
    parameter int QUEUE_DEPTH    = kpsr_pkg::QUEUE_DEPTH_DEF,
    parameter int QUEUE_CAPACITY = kpsr_pkg::QUEUE_CAPACITY_DEF,
    parameter int TICK_MS        = kpsr_pkg::TICK_MS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire kpsr_pkg::t_in_word              i_in_word,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output kpsr_pkg::t_out_word                  o_out_word,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [kpsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [kpsr_pkg::CFG_W-1:0]      i_cfg_data
);

    // configuration registers
    logic                         r_repeat_en;
    logic [kpsr_pkg::TMO_W-1:0]   r_repeat_tmo;

    // pending codes from the last tick, oldest in slot 0
    logic [kpsr_pkg::CODE_W-1:0]  r_pend [3];
    logic [kpsr_pkg::CODE_W-1:0]  n_pend [3];
    logic [1:0]                   r_pend_cnt, n_pend_cnt;

    // read waiting for the memory port, and output word valid
    logic                         r_rd_req, n_rd_req;
    logic                         r_out_v, n_out_v;

    kpsr_pkg::t_scan_codes        scan_codes;
    logic                         in_acc;
    logic                         tick_acc;
    logic                         read_acc;
    logic                         out_acc;
    logic                         rd_issue;
    logic                         wr_en;
    logic [1:0]                   new_idx;

    // ---------------------------------------------------------------------
    // configuration writes: the timeout only takes while repeat is on
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_en  <= 1'b0;
            r_repeat_tmo <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kpsr_pkg::REG_REPEAT_ENABLE: begin
                    r_repeat_en <= i_cfg_data[0];
                end
                kpsr_pkg::REG_REPEAT_TIMEOUT: begin
                    if (r_repeat_en) begin
                        r_repeat_tmo <= i_cfg_data[kpsr_pkg::TMO_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // handshake and ordering
    // ---------------------------------------------------------------------
    always_comb begin
        // pending writes go first, so a read sees every earlier tick's codes
        wr_en    = (r_pend_cnt != 2'd0);
        rd_issue = r_rd_req && !wr_en && (!r_out_v || i_out_ready);

        // take a word once the pending list empties this cycle and no read is stuck
        o_in_ready = ((r_pend_cnt <= 2'd1) && !r_rd_req) || rd_issue;
        in_acc     = i_in_valid && o_in_ready;
        tick_acc   = in_acc && (i_in_word.command == kpsr_pkg::CMD_TICK);
        read_acc   = in_acc && (i_in_word.command == kpsr_pkg::CMD_READ);
        out_acc    = r_out_v && i_out_ready;

        n_rd_req = read_acc ? 1'b1 : (rd_issue ? 1'b0 : r_rd_req);
        n_out_v  = rd_issue ? 1'b1 : (out_acc ? 1'b0 : r_out_v);

        // a tick is only accepted when the list is empty after this cycle
        n_pend[0]  = r_pend[1];
        n_pend[1]  = r_pend[2];
        n_pend[2]  = r_pend[2];
        n_pend_cnt = wr_en ? r_pend_cnt - 2'd1 : r_pend_cnt;
        new_idx    = 2'd0;
        if (tick_acc) begin
            if (scan_codes.key_v) begin
                n_pend[new_idx] = scan_codes.key_code;
                new_idx         = new_idx + 2'd1;
            end
            if (scan_codes.rst_v) begin
                n_pend[new_idx] = kpsr_pkg::RESET_CODE;
                new_idx         = new_idx + 2'd1;
            end
            if (scan_codes.vid_v) begin
                n_pend[new_idx] = kpsr_pkg::VIDEO_CODE;
                new_idx         = new_idx + 2'd1;
            end
            n_pend_cnt = new_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
            r_rd_req   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_pend_cnt <= n_pend_cnt;
            r_rd_req   <= n_rd_req;
            r_out_v    <= n_out_v;
        end
    end

    // code payload, no reset
    always_ff @(posedge i_clk) begin
        r_pend[0] <= n_pend[0];
        r_pend[1] <= n_pend[1];
        r_pend[2] <= n_pend[2];
    end

    // ---------------------------------------------------------------------
    // scan logic and queue
    // ---------------------------------------------------------------------
    kpsr_scan #(
        .TICK_MS (TICK_MS)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (tick_acc),
        .i_key_lines      (i_in_word.key_lines),
        .i_reset_button   (i_in_word.reset_button),
        .i_video_detect   (i_in_word.video_detect),
        .i_repeat_enable  (r_repeat_en),
        .i_repeat_timeout (r_repeat_tmo),
        .o_codes          (scan_codes)
    );

    kpsr_queue #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .QUEUE_CAPACITY (QUEUE_CAPACITY)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_code (r_pend[0]),
        .i_rd_en   (rd_issue),
        .o_rd_word (o_out_word)
    );

    assign o_out_valid = r_out_v;

`ifndef SYNTHESIS
    a_stuck_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_req && !rd_issue) |-> !o_in_ready)
        else $error("word accepted ahead of a waiting read");
    a_issue_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_issue |-> (!r_out_v || i_out_ready))
        else $error("read issued over an untaken output word");
    a_issue_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_issue |=> r_out_v)
        else $error("issued read produced no output word");
    a_tick_list_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |-> (r_pend_cnt <= 2'd1))
        else $error("tick accepted with codes still pending");
`endif

endmodule

`default_nettype wire
